[src/psc_pkg.sv]
`default_nettype none

package psc_pkg;

	// Converter resolution; raw words are masked to this many low bits.
	localparam int ADC_BITS = 24;
	localparam int RAW_W = 24;
	localparam logic [RAW_W-1:0] ADC_MASK = RAW_W'((64'd1 << ADC_BITS) - 64'd1);

	localparam int CAL_W = 16;
	localparam int CFG_IDX_W = 3;

	localparam int TEMP_OUT_W = 19;
	localparam int PRES_OUT_W = 32;

	// Internal widths of the values handed from the temperature half to the pressure half.
	localparam int TC_W = 20;
	localparam int OFF_W = 41;
	localparam int SENS_W = 40;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_C1 = 3'd0,
		REG_C2 = 3'd1,
		REG_C3 = 3'd2,
		REG_C4 = 3'd3,
		REG_C5 = 3'd4,
		REG_C6 = 3'd5
	} cfg_reg_t;

	typedef struct packed {
		logic [CAL_W-1:0] c1;
		logic [CAL_W-1:0] c2;
		logic [CAL_W-1:0] c3;
		logic [CAL_W-1:0] c4;
		logic [CAL_W-1:0] c5;
		logic [CAL_W-1:0] c6;
	} cal_t;

	typedef struct packed {
		logic valid;
		logic [RAW_W-1:0] d1;
		logic signed [TC_W-1:0] temp;
		logic signed [OFF_W-1:0] off;
		logic signed [SENS_W-1:0] sens;
	} mid_t;

endpackage

`default_nettype wire

[src/psc_cfg_regs.sv]
`default_nettype none

module psc_cfg_regs import psc_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [CFG_IDX_W-1:0] cfg_index,
	input logic [CAL_W-1:0] cfg_wdata,
	output cal_t cal
);

	cal_t cal_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_C1: begin
					cal_q.c1 <= cfg_wdata;
				end
				REG_C2: begin
					cal_q.c2 <= cfg_wdata;
				end
				REG_C3: begin
					cal_q.c3 <= cfg_wdata;
				end
				REG_C4: begin
					cal_q.c4 <= cfg_wdata;
				end
				REG_C5: begin
					cal_q.c5 <= cfg_wdata;
				end
				REG_C6: begin
					cal_q.c6 <= cfg_wdata;
				end
				default: begin
					cal_q <= cal_q;
				end
			endcase
		end
	end

	assign cal = cal_q;

endmodule

`default_nettype wire

[src/psc_temp_stage.sv]
`default_nettype none

module psc_temp_stage import psc_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic [RAW_W-1:0] raw_t,
	input logic [RAW_W-1:0] raw_p,
	input cal_t cal,
	output mid_t mid
);

	localparam int DT_W = RAW_W + 1;
	localparam int MUL_W = DT_W + CAL_W + 1;
	localparam int DT2_W = 2 * RAW_W + 1;
	localparam int A_W = 18;
	localparam int SQ_W = 2 * A_W - 1;
	localparam int T2_W = 17;
	localparam int OFF2_W = 40;
	localparam int SENS2_W = 39;
	localparam int TC_SHIFT = 23;
	localparam int T2_LO_SHIFT = 33;
	localparam int T2_HI_SHIFT = 38;
	localparam int OFF_SHIFT = 6;
	localparam int SENS_SHIFT = 7;
	localparam int TEMP_REF = 2000;
	localparam int TEMP_VLOW = -1500;
	localparam int VLOW_GAP = TEMP_REF - TEMP_VLOW;
	localparam logic signed [A_W-1:0] VLOW_A = A_W'(-VLOW_GAP);

	// Stage 1: temperature difference.
	logic signed [DT_W-1:0] dt_c;
	logic valid_s1;
	logic signed [DT_W-1:0] dt_s1;
	logic [RAW_W-1:0] d1_s1;

	assign dt_c = $signed({1'b0, raw_t & ADC_MASK}) - $signed({1'b0, cal.c5, 8'b0});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		dt_s1 <= dt_c;
		d1_s1 <= raw_p & ADC_MASK;
	end

	// Stage 2: every product of dT.
	logic valid_s2;
	logic signed [MUL_W-1:0] tc_s2;
	logic signed [MUL_W-1:0] offc_s2;
	logic signed [MUL_W-1:0] sensc_s2;
	logic [DT2_W-1:0] dt2_s2;
	logic [RAW_W-1:0] d1_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		tc_s2 <= dt_s1 * $signed({1'b0, cal.c6});
		offc_s2 <= dt_s1 * $signed({1'b0, cal.c4});
		sensc_s2 <= dt_s1 * $signed({1'b0, cal.c3});
		dt2_s2 <= dt_s1 * dt_s1;
		d1_s2 <= d1_s1;
	end

	// Stage 3: branch selection, T2 and the linear offset and sensitivity.
	logic signed [A_W-1:0] a_c;
	logic low_c;
	logic vlow_c;
	logic [DT2_W+1:0] dt2_x3;
	logic [DT2_W+1:0] dt2_x5;
	logic [T2_W-1:0] t2_c;
	logic signed [A_W-1:0] b_c;
	logic signed [A_W-1:0] asq_c;

	assign a_c = $signed(tc_s2[TC_SHIFT +: A_W]);
	assign low_c = a_c[A_W-1];
	assign vlow_c = a_c < VLOW_A;
	assign dt2_x3 = (DT2_W + 2)'(dt2_s2) + (DT2_W + 2)'({dt2_s2, 1'b0});
	assign dt2_x5 = (DT2_W + 2)'(dt2_s2) + {dt2_s2, 2'b0};
	assign t2_c = low_c ? T2_W'(dt2_x3 >> T2_LO_SHIFT) : T2_W'(dt2_x5 >> T2_HI_SHIFT);
	// Zeroed operands make the squares, and with them both corrections, vanish.
	assign asq_c = low_c ? a_c : '0;
	assign b_c = vlow_c ? a_c + A_W'(VLOW_GAP) : '0;

	logic valid_s3;
	logic signed [A_W-1:0] a_s3;
	logic signed [A_W-1:0] asq_s3;
	logic signed [A_W-1:0] b_s3;
	logic [T2_W-1:0] t2_s3;
	logic signed [OFF_W-1:0] off_lin_s3;
	logic signed [SENS_W-1:0] sens_lin_s3;
	logic [RAW_W-1:0] d1_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		a_s3 <= a_c;
		asq_s3 <= asq_c;
		b_s3 <= b_c;
		t2_s3 <= t2_c;
		off_lin_s3 <= $signed({8'b0, cal.c2, 17'b0}) + OFF_W'(offc_s2 >>> OFF_SHIFT);
		sens_lin_s3 <= $signed({8'b0, cal.c1, 16'b0}) + SENS_W'(sensc_s2 >>> SENS_SHIFT);
		d1_s3 <= d1_s2;
	end

	// Stage 4: squares and the compensated temperature.
	logic signed [2*A_W-1:0] asq_sq_c;
	logic signed [2*A_W-1:0] b_sq_c;

	assign asq_sq_c = asq_s3 * asq_s3;
	assign b_sq_c = b_s3 * b_s3;

	logic valid_s4;
	logic [SQ_W-1:0] sq_s4;
	logic [SQ_W-1:0] sq2_s4;
	logic signed [TC_W-1:0] temp_s4;
	logic signed [OFF_W-1:0] off_lin_s4;
	logic signed [SENS_W-1:0] sens_lin_s4;
	logic [RAW_W-1:0] d1_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else begin
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		sq_s4 <= asq_sq_c[SQ_W-1:0];
		sq2_s4 <= b_sq_c[SQ_W-1:0];
		temp_s4 <= TC_W'(TEMP_REF) + TC_W'(a_s3) - $signed({{(TC_W - T2_W){1'b0}}, t2_s3});
		off_lin_s4 <= off_lin_s3;
		sens_lin_s4 <= sens_lin_s3;
		d1_s4 <= d1_s3;
	end

	// Stage 5: second-order offset and sensitivity corrections.
	logic [SQ_W+5:0] sq_x61;
	logic [SQ_W+4:0] sq_x29;
	logic [SQ_W+4:0] sq2_x17;
	logic [SQ_W+3:0] sq2_x9;

	assign sq_x61 = (SQ_W + 6)'(sq_s4) * (SQ_W + 6)'(61);
	assign sq_x29 = (SQ_W + 5)'(sq_s4) * (SQ_W + 5)'(29);
	assign sq2_x17 = (SQ_W + 5)'(sq2_s4) * (SQ_W + 5)'(17);
	assign sq2_x9 = (SQ_W + 4)'(sq2_s4) * (SQ_W + 4)'(9);

	logic valid_s5;
	logic [OFF2_W-1:0] off2_s5;
	logic [SENS2_W-1:0] sens2_s5;
	logic signed [TC_W-1:0] temp_s5;
	logic signed [OFF_W-1:0] off_lin_s5;
	logic signed [SENS_W-1:0] sens_lin_s5;
	logic [RAW_W-1:0] d1_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s5 <= 1'b0;
		end else begin
			valid_s5 <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		off2_s5 <= OFF2_W'(sq_x61 >> 4) + OFF2_W'(sq2_x17);
		sens2_s5 <= SENS2_W'(sq_x29 >> 4) + SENS2_W'(sq2_x9);
		temp_s5 <= temp_s4;
		off_lin_s5 <= off_lin_s4;
		sens_lin_s5 <= sens_lin_s4;
		d1_s5 <= d1_s4;
	end

	// Stage 6: final offset and sensitivity.
	logic valid_s6;
	logic signed [OFF_W-1:0] off_s6;
	logic signed [SENS_W-1:0] sens_s6;
	logic signed [TC_W-1:0] temp_s6;
	logic [RAW_W-1:0] d1_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s6 <= 1'b0;
		end else begin
			valid_s6 <= valid_s5;
		end
	end

	always_ff @(posedge clk) begin
		off_s6 <= off_lin_s5 - $signed({1'b0, off2_s5});
		sens_s6 <= sens_lin_s5 - $signed({1'b0, sens2_s5});
		temp_s6 <= temp_s5;
		d1_s6 <= d1_s5;
	end

	assign mid.valid = valid_s6;
	assign mid.d1 = d1_s6;
	assign mid.temp = temp_s6;
	assign mid.off = off_s6;
	assign mid.sens = sens_s6;

`ifndef SYNTHESIS
	// The very cold branch only ever adds to the cold branch.
	a_vlow_in_low: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 && (b_s3 != '0) |-> (asq_s3 == a_s3) && a_s3[A_W-1])
		else $error("very cold correction outside the cold branch");

	a_warm_no_corr: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 && !a_s3[A_W-1] |=> ##1 (off2_s5 == '0) && (sens2_s5 == '0))
		else $error("offset or sensitivity correction applied above reference");

	a_warm_t2_bound: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 && !a_s3[A_W-1] |-> t2_s3 <= T2_W'(5 << (2 * RAW_W - T2_HI_SHIFT)))
		else $error("warm T2 exceeds its bound");
`endif

endmodule

`default_nettype wire

[src/psc_press_stage.sv]
`default_nettype none

module psc_press_stage import psc_pkg::*; (
	input logic clk,
	input logic arst_n,
	input mid_t mid,
	output logic done,
	output logic signed [TEMP_OUT_W-1:0] temperature_centi,
	output logic signed [PRES_OUT_W-1:0] pressure_pa
);

	localparam int LO_W = 20;
	localparam int HI_W = SENS_W - LO_W;
	localparam int PP_LO_W = RAW_W + LO_W;
	localparam int PP_HI_W = RAW_W + 1 + HI_W;
	localparam int PROD_W = 64;
	localparam int PROD_SHIFT = 21;
	localparam int P_SHIFT = 15;
	localparam int DIFF_W = PROD_W - PROD_SHIFT + 1;
	localparam logic signed [DIFF_W-1:0] P_HI =
		{{(DIFF_W - PRES_OUT_W + 1){1'b0}}, {(PRES_OUT_W - 1){1'b1}}};
	localparam logic signed [DIFF_W-1:0] P_LO = ~P_HI;
	localparam logic signed [TC_W-1:0] T_HI =
		{{(TC_W - TEMP_OUT_W + 1){1'b0}}, {(TEMP_OUT_W - 1){1'b1}}};
	localparam logic signed [TC_W-1:0] T_LO = ~T_HI;

	// Stage 7: D1 times sensitivity as two partial products.
	logic valid_s7;
	logic [PP_LO_W-1:0] pp_lo_s7;
	logic signed [PP_HI_W-1:0] pp_hi_s7;
	logic signed [OFF_W-1:0] off_s7;
	logic signed [TC_W-1:0] temp_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s7 <= 1'b0;
		end else begin
			valid_s7 <= mid.valid;
		end
	end

	always_ff @(posedge clk) begin
		pp_lo_s7 <= PP_LO_W'(mid.d1) * PP_LO_W'(mid.sens[LO_W-1:0]);
		pp_hi_s7 <= $signed({1'b0, mid.d1}) * $signed(mid.sens[SENS_W-1:LO_W]);
		off_s7 <= mid.off;
		temp_s7 <= mid.temp;
	end

	// Stage 8: recombine the full product.
	logic valid_s8;
	logic signed [PROD_W-1:0] prod_s8;
	logic signed [OFF_W-1:0] off_s8;
	logic signed [TC_W-1:0] temp_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s8 <= 1'b0;
		end else begin
			valid_s8 <= valid_s7;
		end
	end

	always_ff @(posedge clk) begin
		prod_s8 <= (PROD_W'(pp_hi_s7) <<< LO_W)
			+ $signed({{(PROD_W - PP_LO_W){1'b0}}, pp_lo_s7});
		off_s8 <= off_s7;
		temp_s8 <= temp_s7;
	end

	// Stage 9: pressure, then saturation of both results.
	logic signed [DIFF_W-1:0] diff_c;
	logic signed [DIFF_W-1:0] p_c;
	logic signed [PRES_OUT_W-1:0] p_sat_c;
	logic signed [TEMP_OUT_W-1:0] t_sat_c;

	assign diff_c = DIFF_W'(prod_s8 >>> PROD_SHIFT) - DIFF_W'(off_s8);
	assign p_c = diff_c >>> P_SHIFT;

	always_comb begin
		if (p_c > P_HI) begin
			p_sat_c = P_HI[PRES_OUT_W-1:0];
		end else if (p_c < P_LO) begin
			p_sat_c = P_LO[PRES_OUT_W-1:0];
		end else begin
			p_sat_c = p_c[PRES_OUT_W-1:0];
		end
		if (temp_s8 > T_HI) begin
			t_sat_c = T_HI[TEMP_OUT_W-1:0];
		end else if (temp_s8 < T_LO) begin
			t_sat_c = T_LO[TEMP_OUT_W-1:0];
		end else begin
			t_sat_c = temp_s8[TEMP_OUT_W-1:0];
		end
	end

	logic done_s9;
	logic signed [TEMP_OUT_W-1:0] temp_out_s9;
	logic signed [PRES_OUT_W-1:0] pres_out_s9;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s9 <= 1'b0;
		end else begin
			done_s9 <= valid_s8;
		end
	end

	always_ff @(posedge clk) begin
		temp_out_s9 <= t_sat_c;
		pres_out_s9 <= p_sat_c;
	end

	assign done = done_s9;
	assign temperature_centi = temp_out_s9;
	assign pressure_pa = pres_out_s9;

`ifndef SYNTHESIS
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		done_s9 == $past(mid.valid, 3))
		else $error("result strobe out of step with the pipeline");

	a_zero_d1: assert property (@(posedge clk) disable iff (!arst_n)
		mid.valid && (mid.d1 == '0) |=> ##1 prod_s8 == '0)
		else $error("partial products do not recombine for zero pressure word");

	a_zero_sens: assert property (@(posedge clk) disable iff (!arst_n)
		mid.valid && (mid.sens == '0) |=> ##1 prod_s8 == '0)
		else $error("partial products do not recombine for zero sensitivity");
`endif

endmodule

`default_nettype wire

[src/pressure_sensor_compensation_unit.sv]
`default_nettype none

// Second-order compensation for a barometric pressure sensor.
// Software loads the six 16-bit calibration words through cfg_we, cfg_index
// and cfg_wdata; a write takes effect at the clock edge where cfg_we is high,
// and indexes beyond the sixth word are ignored. Load them while no word is
// in flight.
// A word (raw temperature and raw pressure) is taken at each edge where start
// is high and busy is low. busy never rises, so one word can enter every cycle.
// The datapath is a nine-stage pipeline; each word taken comes out with done
// high for a single cycle, together with temperature_centi (hundredths of a
// degree) and pressure_pa (pascals).
// Throughput is one word per cycle; the latency is set by the chain of dT
// products, squares, correction terms and the split D1-times-sensitivity
// multiply. The receiver must take each result in its strobe cycle.
// Reset clears the calibration words to zero and empties the pipeline.

module pressure_sensor_compensation_unit import psc_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input logic [RAW_W-1:0] raw_temperature,
	input logic [RAW_W-1:0] raw_pressure,
	output logic done,
	output logic signed [TEMP_OUT_W-1:0] temperature_centi,
	output logic signed [PRES_OUT_W-1:0] pressure_pa,
	input logic cfg_we,
	input logic [CFG_IDX_W-1:0] cfg_index,
	input logic [CAL_W-1:0] cfg_wdata
);

	cal_t cal;
	mid_t mid;
	logic accept;

	assign busy = 1'b0;
	assign accept = start && !busy;

	psc_cfg_regs u_cfg (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.cal(cal)
	);

	psc_temp_stage u_temp (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(accept),
		.raw_t(raw_temperature),
		.raw_p(raw_pressure),
		.cal(cal),
		.mid(mid)
	);

	psc_press_stage u_press (
		.clk(clk),
		.arst_n(arst_n),
		.mid(mid),
		.done(done),
		.temperature_centi(temperature_centi),
		.pressure_pa(pressure_pa)
	);

endmodule

`default_nettype wire
